// ----- hw/rtl/arxae_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ARX sponge AEAD package
// Shared constants, operation codes and the G-function step schedule.
// ----------------------------------------------------------------------------
package arxae_pkg;

    localparam int unsigned WORD_W      = 64;
    localparam int unsigned NUM_WORDS   = 16;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned ROUNDS_DEF  = 4;
    localparam int unsigned CRYPT_WORDS = 12;
    localparam int unsigned TAG_BITS    = 256;
    localparam int unsigned CFG_IDX_W   = 2;

    typedef enum logic [2:0] {
        OP_INIT      = 3'd0,
        OP_IV_HIGH   = 3'd1,
        OP_ABSORB    = 3'd2,
        OP_ENCRYPT   = 3'd3,
        OP_DECRYPT   = 3'd4,
        OP_PHASE_END = 3'd5,
        OP_FINALISE  = 3'd6,
        OP_UNUSED    = 3'd7
    } op_t;

    // One G application: indexes of the four words it touches.
    typedef struct packed {
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
        logic [IDX_W-1:0] d;
    } quad_t;

    // Permutation unit control handed from the sequencer.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } perm_ctl_t;

    // Column mixes for g 0..3, diagonal mixes for g 4..7.
    function automatic quad_t quad_of(input logic [2:0] g);
        quad_t q;
        logic [1:0] i;
        i = g[1:0];
        q.a = {2'b00, i};
        if (!g[2])
        begin
            q.b = {2'b01, i};
            q.c = {2'b10, i};
            q.d = {2'b11, i};
        end
        else
        begin
            q.b = {2'b01, 2'(i + 2'd1)};
            q.c = {2'b10, 2'(i + 2'd2)};
            q.d = {2'b11, 2'(i + 2'd3)};
        end
        return q;
    endfunction

    function automatic logic [WORD_W-1:0] byte_mask(input logic [3:0] n);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (n > 4'(k))
            begin
                m[k*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/arxae_perm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ARX sponge AEAD permutation unit
// Holds the sixteen state words and runs the permutation one G function
// per cycle: a, d, c, b are updated in four chained add-xor-rotate steps.
// ----------------------------------------------------------------------------
module arxae_perm #(
    parameter int unsigned ROUNDS = arxae_pkg::ROUNDS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire arxae_pkg::perm_ctl_t            ctl_in,
    output      arxae_pkg::perm_ctl_t            ctl_out,
    input  wire logic                            wr_en,
    input  wire logic [arxae_pkg::IDX_W-1:0]     wr_idx,
    input  wire logic [arxae_pkg::WORD_W-1:0]    wr_data,
    input  wire logic                            init_en,
    input  wire logic [arxae_pkg::WORD_W*16-1:0] init_data,
    input  wire logic [arxae_pkg::IDX_W-1:0]     rd_idx,
    output      logic [arxae_pkg::WORD_W-1:0]    rd_data
);
    localparam int unsigned CNT_W = $clog2(ROUNDS * 8 + 1);
    localparam int unsigned STEPS = ROUNDS * 8;

    logic [arxae_pkg::WORD_W-1:0] st_reg [arxae_pkg::NUM_WORDS];
    logic [CNT_W-1:0]             cnt_reg;
    logic                         busy_reg;
    arxae_pkg::quad_t             q;
    logic [63:0] a0, b0, c0, d0, a1, d1, c1, b1, a2, d2, c2, b2;

    assign q  = arxae_pkg::quad_of(cnt_reg[2:0]);
    assign a0 = st_reg[q.a];
    assign b0 = st_reg[q.b];
    assign c0 = st_reg[q.c];
    assign d0 = st_reg[q.d];

    always_comb
    begin
        a1 = a0 + b0;
        d1 = 64'(({(d0 ^ a1), (d0 ^ a1)}) >> 32);
        c1 = c0 + d1;
        b1 = 64'(({(b0 ^ c1), (b0 ^ c1)}) >> 24);
        a2 = a1 + b1;
        d2 = 64'(({(d1 ^ a2), (d1 ^ a2)}) >> 16);
        c2 = c1 + d2;
        b2 = 64'(({(b1 ^ c2), (b1 ^ c2)}) >> 63);
    end

    assign rd_data       = st_reg[rd_idx];
    assign ctl_out.start = 1'b0;
    assign ctl_out.busy  = busy_reg;
    assign ctl_out.done  = busy_reg && (cnt_reg == CNT_W'(STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            for (int k = 0; k < 16; k++)
            begin
                st_reg[k] <= '0;
            end
        end
        else
        begin
            if (busy_reg)
            begin
                st_reg[q.a] <= a2;
                st_reg[q.b] <= b2;
                st_reg[q.c] <= c2;
                st_reg[q.d] <= d2;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    cnt_reg  <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            else if (ctl_in.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (init_en)
            begin
                for (int k = 0; k < 16; k++)
                begin
                    st_reg[k] <= init_data[k*64 +: 64];
                end
            end
            else if (wr_en)
            begin
                st_reg[wr_idx] <= wr_data;
            end
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/arx_sponge_aead_engine_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ARX sponge AEAD engine
// Word-serial AEAD engine around a 1024-bit add-rotate-xor permutation.
// ----------------------------------------------------------------------------
// Init, phase_end and the unused code are taken in the idle state; iv_high,
// absorb and crypt words pass through a word state, and a crypt word then
// passes through an output state. A permutation, due before the first word of
// every absorb or crypt block, runs in the permutation unit, which applies one
// G function per cycle. Finalise runs two permutations, mixing the length
// words into state words 0 and 1 between them, then emits four tag words.
// Results leave through an output register, and the input side is not ready
// while an item is in progress or a result waits.
module arx_sponge_aead_engine_unit #(
    parameter int unsigned ROUNDS = arxae_pkg::ROUNDS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    // [63:0] data_word, [127:64] aux_word, [131:128] byte_count
    input  wire logic [135:0] s_tdata,
    // [2:0] operation, [3] domain
    input  wire logic [3:0]   s_tuser,
    output      logic         m_tvalid,
    input  wire logic         m_tready,
    // [63:0] out_word
    output      logic [63:0]  m_tdata,
    output      logic         m_tlast,
    input  wire logic         cfg_valid,
    output      logic         cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [63:0]  cfg_data
);
    typedef enum logic [2:0] {
        S_IDLE, S_PERM1, S_WORD, S_PERM2, S_TAG, S_OUT
    } state_t;

    state_t            state_reg;
    logic [63:0]       key_reg [4];
    logic [3:0]        pos_reg;
    logic [2:0]        op_reg;
    logic [63:0]       data_reg, aux_reg;
    logic [3:0]        bc_reg;
    logic [2:0]        tag_reg;
    logic [63:0]       out_reg;
    logic              last_reg, ov_reg;
    logic              ivw_reg;

    arxae_pkg::perm_ctl_t pc_in, pc_out;
    logic              wr_en, init_en;
    logic [3:0]        wr_idx, rd_idx;
    logic [63:0]       wr_data, rd_data, mask;
    logic [1023:0]     init_data;
    logic [2:0]        in_op;
    logic              out_load;

    assign in_op     = s_tuser[2:0];
    assign s_tready  = (state_reg == S_IDLE) && !ov_reg;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = ov_reg;
    assign m_tdata   = out_reg;
    assign m_tlast   = last_reg;
    assign mask      = arxae_pkg::byte_mask(bc_reg);

    always_comb
    begin
        init_data = '0;
        init_data[0 +: 64]    = s_tdata[63:0];
        init_data[64 +: 64]   = s_tdata[127:64];
        init_data[9*64 +: 64] = 64'(ROUNDS);
        init_data[10*64 +: 64] = 64'(arxae_pkg::TAG_BITS);
        init_data[11*64 +: 64] = {63'd0, s_tuser[3]};
        for (int k = 0; k < 4; k++)
        begin
            init_data[(12+k)*64 +: 64] = key_reg[k];
        end
    end

    logic s_fire;
    assign s_fire  = s_tvalid && s_tready;
    assign init_en = s_fire && (in_op == arxae_pkg::OP_INIT);

    // A new result is loaded by a crypt word or by each tag word.
    assign out_load = ((state_reg == S_WORD) &&
                       (op_reg == arxae_pkg::OP_ENCRYPT || op_reg == arxae_pkg::OP_DECRYPT))
                   || ((state_reg == S_TAG) && (!ov_reg || m_tready));

    // Start a permutation on entry to either permutation state.
    always_comb
    begin
        pc_in = '0;
        pc_in.start = (state_reg == S_PERM1 || state_reg == S_PERM2) && !pc_out.busy;
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = pos_reg;
        wr_data = rd_data ^ data_reg;
        rd_idx  = pos_reg;
        if (state_reg == S_TAG)
        begin
            rd_idx = {2'b00, tag_reg[1:0]};
        end
        if (ivw_reg)
        begin
            // Registered from iv_high's word state, ivw_reg writes the upper tag word 3.
            wr_en   = 1'b1;
            wr_idx  = 4'd3;
            wr_data = aux_reg;
        end
        if (state_reg == S_WORD)
        begin
            wr_en = 1'b1;
            unique case (op_reg)
                arxae_pkg::OP_IV_HIGH:
                begin
                    wr_idx  = 4'd2;
                    wr_data = data_reg;
                end
                arxae_pkg::OP_ABSORB:   wr_data = rd_data ^ data_reg;
                arxae_pkg::OP_ENCRYPT:  wr_data = rd_data ^ (data_reg & mask);
                arxae_pkg::OP_DECRYPT:  wr_data = (data_reg & mask) | (rd_data & ~mask);
                arxae_pkg::OP_FINALISE: wr_data = rd_data ^ data_reg;
                default:                wr_data = rd_data;
            endcase
        end
    end

    arxae_perm #(.ROUNDS(ROUNDS)) u_perm (
        .clk(clk), .rst_n(rst_n), .ctl_in(pc_in), .ctl_out(pc_out),
        .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data),
        .init_en(init_en), .init_data(init_data),
        .rd_idx(rd_idx), .rd_data(rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            ov_reg    <= 1'b0;
            tag_reg   <= '0;
            ivw_reg   <= 1'b0;
            op_reg    <= '0;
            data_reg  <= '0;
            aux_reg   <= '0;
            bc_reg    <= '0;
            out_reg   <= '0;
            last_reg  <= 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                key_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                key_reg[cfg_index] <= cfg_data;
            end
            if (out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (ov_reg && m_tready)
            begin
                ov_reg <= 1'b0;
            end
            ivw_reg <= (state_reg == S_WORD) && (op_reg == arxae_pkg::OP_IV_HIGH);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_fire)
                    begin
                        op_reg   <= in_op;
                        data_reg <= s_tdata[63:0];
                        aux_reg  <= s_tdata[127:64];
                        bc_reg   <= s_tdata[131:128];
                        unique case (in_op)
                            arxae_pkg::OP_INIT: pos_reg <= '0;
                            arxae_pkg::OP_IV_HIGH: state_reg <= S_WORD;
                            arxae_pkg::OP_ABSORB:
                                state_reg <= (pos_reg == 4'd0) ? S_PERM1 : S_WORD;
                            arxae_pkg::OP_ENCRYPT, arxae_pkg::OP_DECRYPT:
                            begin
                                if (pos_reg == 4'd0 || pos_reg >= 4'd12)
                                begin
                                    pos_reg   <= '0;
                                    state_reg <= S_PERM1;
                                end
                                else
                                begin
                                    state_reg <= S_WORD;
                                end
                            end
                            arxae_pkg::OP_PHASE_END: pos_reg <= '0;
                            arxae_pkg::OP_FINALISE:
                            begin
                                pos_reg   <= '0;
                                state_reg <= S_PERM1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_PERM1:
                begin
                    if (pc_out.done)
                    begin
                        state_reg <= S_WORD;
                    end
                end
                S_WORD:
                begin
                    // Iv_high writes word 2 here and word 3 through ivw_reg.
                    if (op_reg == arxae_pkg::OP_ENCRYPT || op_reg == arxae_pkg::OP_DECRYPT)
                    begin
                        out_reg   <= (op_reg == arxae_pkg::OP_ENCRYPT)
                                     ? ((rd_data ^ (data_reg & mask)) & mask)
                                     : ((data_reg ^ rd_data) & mask);
                        last_reg  <= 1'b1;
                        pos_reg   <= (pos_reg == 4'd11) ? 4'd0 : pos_reg + 4'd1;
                        state_reg <= S_OUT;
                    end
                    else if (op_reg == arxae_pkg::OP_ABSORB)
                    begin
                        pos_reg   <= pos_reg + 4'd1;
                        state_reg <= S_IDLE;
                    end
                    else if (op_reg == arxae_pkg::OP_FINALISE)
                    begin
                        if (!tag_reg[2])
                        begin
                            tag_reg   <= 3'b100;
                            data_reg  <= aux_reg;
                            pos_reg   <= 4'd1;
                        end
                        else
                        begin
                            tag_reg   <= '0;
                            pos_reg   <= '0;
                            state_reg <= S_PERM2;
                        end
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_PERM2:
                begin
                    if (pc_out.done)
                    begin
                        state_reg <= S_TAG;
                    end
                end
                S_TAG:
                begin
                    if (!ov_reg || m_tready)
                    begin
                        out_reg  <= rd_data;
                        last_reg <= (tag_reg[1:0] == 2'd3);
                        if (tag_reg[1:0] == 2'd3)
                        begin
                            tag_reg   <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            tag_reg <= tag_reg + 3'd1;
                        end
                    end
                end
                S_OUT:
                begin
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/arxae_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ARX sponge AEAD port checker
// Watches the top-level ports for handshake and sequencing rules.
// ----------------------------------------------------------------------------
module arxae_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tlast
);
    // A stalled result holds its data.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // Handshake signals carry known values once out of reset.
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({s_tvalid, s_tready, m_tvalid}))
        else $error("unknown handshake value");

    // The engine never takes an item while a result waits.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input open with result pending");
endmodule

bind arx_sponge_aead_engine_unit arxae_checker u_arxae_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire
